// ===== hw/rtl/bb_pkg.sv =====
// Shared types, constants and the rounding-divide function of the 3x3 box blur.
// Used by every blur module but bb_ram; depends on nothing.
package bb_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT  = 2048;
  localparam int unsigned OUT_FIFO_DEPTH     = 8;
  localparam int unsigned CFG_IDX_W          = 4;
  localparam int unsigned CFG_DATA_W         = 12;
  localparam int unsigned DIM_W              = 14;
  localparam int unsigned FRAME_WIDTH_RESET  = 640;
  localparam int unsigned FRAME_HEIGHT_RESET = 480;

  // Reciprocals for a 16 bit fixed-point divide; exact for dividends below 2^15.
  localparam logic [16:0] RECIP_UNIT  = 17'd65536;
  localparam logic [16:0] RECIP_THREE = 17'd21846;
  localparam logic [16:0] RECIP_NINE  = 17'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1
  } bb_reg_e;

  // Red sits in the lowest byte, matching the stream packing.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bb_pix_t;

  // One line RAM word: the column's pixel two rows up and one row up.
  typedef struct packed {
    bb_pix_t upper;
    bb_pix_t middle;
  } bb_line_t;

  // One window column, top row first.
  typedef struct packed {
    bb_pix_t top;
    bb_pix_t mid;
    bb_pix_t bot;
  } bb_col_t;

  // Per-beat control decided at acceptance.
  typedef struct packed {
    bb_pix_t    pix;
    logic       emit;
    logic       frame_end;
    logic [2:0] col_mask;
    logic [2:0] row_mask;
    logic [3:0] n;
  } bb_step_t;

  typedef struct packed {
    logic        frame_end;
    logic [3:0]  n;
    logic [11:0] sum_r;
    logic [11:0] sum_g;
    logic [11:0] sum_b;
  } bb_sum_t;

  typedef struct packed {
    logic    frame_end;
    bb_pix_t pix;
  } bb_res_t;

  // Round half up: (2*sum + n) / (2*n) for n in {1,2,3,4,6,9}.
  // Split 2*n into a power of two (shift) and 1, 3 or 9 (reciprocal multiply).
  function automatic logic [7:0] bb_mean(logic [11:0] sum, logic [3:0] n);
    logic [12:0] x;
    logic [12:0] y;
    logic [16:0] m;
    logic [29:0] p;
    x = {sum, 1'b0} + {9'd0, n};
    case (n)
      4'd2: begin
        y = x >> 2;
        m = RECIP_UNIT;
      end
      4'd3: begin
        y = x >> 1;
        m = RECIP_THREE;
      end
      4'd4: begin
        y = x >> 3;
        m = RECIP_UNIT;
      end
      4'd6: begin
        y = x >> 2;
        m = RECIP_THREE;
      end
      4'd9: begin
        y = x >> 1;
        m = RECIP_NINE;
      end
      default: begin
        y = x >> 1;
        m = RECIP_UNIT;
      end
    endcase
    p = {17'd0, y} * {13'd0, m};
    return p[23:16];
  endfunction

endpackage

// ===== hw/rtl/bb_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
// Used for the blur line buffers; depends on nothing.
module bb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/bb_scan.sv =====
// Raster counters of the blur: decides per beat whether it counts, emits, ends the frame,
// and which neighbors fall inside the frame. Depends on bb_pkg.
module bb_scan #(
  parameter int unsigned MAX_WIDTH = bb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           restart_i,
  input  logic                           accept_i,
  input  logic                           action_i,
  input  bb_pkg::bb_pix_t                pix_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width_i,
  input  logic [11:0]                    height_i,
  output logic                           step_valid_o,
  output bb_pkg::bb_step_t               step_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   addr_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [12:0]   in_row_q, in_row_d;
  logic [11:0]   out_row_q, out_row_d;

  logic          in_frame, emit_a, emit_b, emit, col_last, row_last, frame_end;
  logic [WW-1:0] in_col_p1, out_col_p1;
  logic [1:0]    col_cnt, row_cnt;
  logic [2:0]    col_mask, row_mask;

  always_comb begin
    in_frame   = {1'b0, height_i} > in_row_q;
    emit_a     = (in_col_q == '0) && (in_row_q >= 13'd2);
    emit_b     = (in_col_q != '0) && (in_row_q >= 13'd1);
    emit       = emit_a || emit_b;
    out_col_p1 = WW'(out_col_q) + WW'(1);
    in_col_p1  = WW'(in_col_q) + WW'(1);
    col_last   = out_col_p1 >= width_i;
    row_last   = ({1'b0, out_row_q} + 13'd1) >= {1'b0, height_i};
    frame_end  = emit && col_last && row_last;

    // Window column 2 holds the new column only when the center is not the row's last pixel.
    col_mask = {!emit_a && !col_last, 1'b1, out_col_q != '0};
    row_mask = {!row_last, 1'b1, out_row_q != '0};
    col_cnt  = 2'd1 + {1'b0, col_mask[0]} + {1'b0, col_mask[2]};
    row_cnt  = 2'd1 + {1'b0, row_mask[0]} + {1'b0, row_mask[2]};

    step_valid_o     = accept_i && !(in_frame && action_i);
    step_o.pix       = in_frame ? pix_i : '0;
    step_o.emit      = emit;
    step_o.frame_end = frame_end;
    step_o.col_mask  = col_mask;
    step_o.row_mask  = row_mask;
    step_o.n         = {2'd0, col_cnt} * {2'd0, row_cnt};
    addr_o           = in_col_q;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (restart_i || (step_valid_o && frame_end)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step_valid_o) begin
      if (emit) begin
        if (col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + 12'd1;
        end else begin
          out_col_d = out_col_p1[CW-1:0];
        end
      end
      if (in_col_p1 >= width_i) begin
        in_col_d = '0;
        in_row_d = in_row_q + 13'd1;
      end else begin
        in_col_d = in_col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== hw/rtl/bb_window.sv =====
// Line buffers, 3x3 window and masked neighborhood sums of the blur.
// Depends on bb_pkg and bb_ram.
module bb_window #(
  parameter int unsigned MAX_WIDTH = bb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_valid_i,
  input  bb_pkg::bb_step_t             step_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  output logic                         sum_valid_o,
  output bb_pkg::bb_sum_t              sum_o,
  output logic [1:0]                   pipe_cnt_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic          s1_v_q, s2_v_q, sum_v_q;
  bb_step_t      s1_q, s2_q;
  logic [CW-1:0] s1_addr_q;
  logic          fwd_q;
  bb_line_t      fwd_data_q;
  bb_line_t      rd_data, line, wr_data;
  bb_col_t       win_q [3];
  bb_sum_t       sum_q, sum_d;
  bb_pix_t       tap [9];

  bb_ram #(
    .WIDTH($bits(bb_line_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_v_q),
    .waddr_i(s1_addr_q),
    .wdata_i(wr_data),
    .re_i   (step_valid_i),
    .raddr_i(addr_i),
    .rdata_o(rd_data)
  );

  // The RAM reads old data when the beat ahead writes the same column: forward it.
  always_comb begin
    line           = fwd_q ? fwd_data_q : rd_data;
    wr_data.upper  = line.middle;
    wr_data.middle = s1_q.pix;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tap[3*j]     = win_q[j].top;
      tap[3*j + 1] = win_q[j].mid;
      tap[3*j + 2] = win_q[j].bot;
    end
    sum_d.frame_end = s2_q.frame_end;
    sum_d.n         = s2_q.n;
    sum_d.sum_r     = '0;
    sum_d.sum_g     = '0;
    sum_d.sum_b     = '0;
    for (int k = 0; k < 9; k++) begin
      if (s2_q.col_mask[k/3] && s2_q.row_mask[k%3]) begin
        sum_d.sum_r = sum_d.sum_r + {4'd0, tap[k].red};
        sum_d.sum_g = sum_d.sum_g + {4'd0, tap[k].green};
        sum_d.sum_b = sum_d.sum_b + {4'd0, tap[k].blue};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
      fwd_q   <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      s1_v_q  <= step_valid_i;
      s2_v_q  <= s1_v_q && s1_q.emit;
      sum_v_q <= s2_v_q;
      if (step_valid_i) begin
        fwd_q <= s1_v_q && (s1_addr_q == addr_i);
      end
      if (s1_v_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= '{top: line.upper, mid: line.middle, bot: s1_q.pix};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_valid_i) begin
      s1_q       <= step_i;
      s1_addr_q  <= addr_i;
      fwd_data_q <= wr_data;
    end
    if (s1_v_q) begin
      s2_q <= s1_q;
    end
    if (s2_v_q) begin
      sum_q <= sum_d;
    end
  end

  assign sum_valid_o = sum_v_q;
  assign sum_o       = sum_q;
  assign pipe_cnt_o  = {1'b0, s1_v_q} + {1'b0, s2_v_q} + {1'b0, sum_v_q};

endmodule

// ===== hw/rtl/bb_mean_fifo.sv =====
// Rounding divide of the neighborhood sums and the result queue in front of the output.
// Depends on bb_pkg.
module bb_mean_fifo #(
  parameter int unsigned DEPTH = bb_pkg::OUT_FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bb_pkg::bb_sum_t            sum_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output bb_pkg::bb_res_t            res_o,
  output logic [$clog2(DEPTH+1)-1:0] cnt_o
);
  import bb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  bb_res_t       mem_q [DEPTH];
  bb_res_t       res_d;
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          pop;

  always_comb begin
    res_d.frame_end = sum_i.frame_end;
    res_d.pix.red   = bb_mean(sum_i.sum_r, sum_i.n);
    res_d.pix.green = bb_mean(sum_i.sum_g, sum_i.n);
    res_d.pix.blue  = bb_mean(sum_i.sum_b, sum_i.n);
    pop             = valid_o && ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

  assign valid_o = cnt_q != '0;
  assign res_o   = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule

// ===== hw/rtl/box_blur_3x3_stream_core.sv =====
// Top level of the 3x3 box blur stream core: register file, credit check and wiring.
// Depends on bb_pkg, bb_scan, bb_window, bb_mean_fifo (and bb_ram below bb_window).
//
//   channel | dir | handshake                   | payload
//   --------+-----+-----------------------------+----------------------------------------
//   s_axis  | in  | s_axis_tvalid/s_axis_tready | tdata: red, green, blue; tuser: action
//   m_axis  | out | m_axis_tvalid/m_axis_tready | tdata: red, green, blue; tlast: frame end
//   cfg     | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i (12 bits)
//
// One beat per cycle in steady flow. The input beat behind a result beat passes the line
// RAM's registered read at its accepting edge, then the window shift, the masked sums and
// the rounding divide into the result queue. s_axis_tready drops only while the pipeline
// and the result queue together hold FIFO_DEPTH beats. Reset restores 640x480 and clears
// counters and window; line RAM content needs no clearing, as rows outside the frame are
// masked. A write to a mapped register restarts the frame; cfg_ready_o is always high.
module box_blur_3x3_stream_core #(
  parameter int unsigned MAX_WIDTH  = bb_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned FIFO_DEPTH = bb_pkg::OUT_FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic [0:0]                     s_axis_tuser,   // action[0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned OW = $clog2(FIFO_DEPTH + 4);
  localparam int unsigned RESET_W =
    (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

  logic [WW-1:0] width_q, width_d;
  logic [11:0]   height_q, height_d;
  logic          cfg_we, restart;
  logic [DIM_W-1:0] width_wide;

  logic          accept, step_valid, sum_valid;
  bb_step_t      step;
  logic [CW-1:0] addr;
  bb_sum_t       sum;
  logic [1:0]    pipe_cnt;
  logic [NW-1:0] fifo_cnt;
  logic [OW-1:0] occ;
  bb_res_t       res;

  // Store effective frame dimensions: width 0 acts as 1, above MAX_WIDTH clamps.
  always_comb begin
    cfg_we     = cfg_valid_i && cfg_ready_o;
    restart    = 1'b0;
    width_d    = width_q;
    height_d   = height_q;
    width_wide = {{(DIM_W - CFG_DATA_W){1'b0}}, cfg_data_i};
    if (width_wide == '0) begin
      width_wide = DIM_W'(1);
    end else if (width_wide > DIM_W'(MAX_WIDTH)) begin
      width_wide = DIM_W'(MAX_WIDTH);
    end
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          width_d = width_wide[WW-1:0];
          restart = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          height_d = (cfg_data_i == '0) ? 12'd1 : cfg_data_i;
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RESET_W);
      height_q <= 12'(FRAME_HEIGHT_RESET);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Reserve a queue slot for every beat in flight; stall the input only when none is left.
  assign occ           = OW'(pipe_cnt) + OW'(fifo_cnt);
  assign s_axis_tready = occ < OW'(FIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  bb_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .accept_i    (accept),
    .action_i    (s_axis_tuser[0]),
    .pix_i       (bb_pix_t'(s_axis_tdata)),
    .width_i     (width_q),
    .height_i    (height_q),
    .step_valid_o(step_valid),
    .step_o      (step),
    .addr_o      (addr)
  );

  bb_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_valid_i(step_valid),
    .step_i      (step),
    .addr_i      (addr),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .pipe_cnt_o  (pipe_cnt)
  );

  bb_mean_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_mean_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (sum_valid),
    .sum_i  (sum),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res),
    .cnt_o  (fifo_cnt)
  );

  assign m_axis_tdata = res.pix;
  assign m_axis_tlast = res.frame_end;

`ifndef SYNTHESIS
  // Credit check must keep the queue from ever overfilling.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OW'(FIFO_DEPTH))
    else $error("beats in flight exceed result queue depth");

  // A result beat cannot appear out of an empty pipeline.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && occ == '0) |=> !m_axis_tvalid)
    else $error("result beat without a beat in flight");

  // Input back-pressure only when all credits are taken.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (occ == OW'(FIFO_DEPTH)))
    else $error("input stalled with credits free");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for box_blur_3x3_stream_core: stream in, blurred stream out.
// Predicts every blurred pixel on its own and compares each output beat field by field.
// Depends on bb_pkg and the blur core RTL only.
`timescale 1ns / 100ps

module tb;
  import bb_pkg::*;

  localparam int unsigned LINE_LEN    = MAX_WIDTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYC  = 32;     // pipeline plus result queue, with margin
  localparam int unsigned PHASE_BEATS = 210;

  localparam bit ACT_PIXEL = 1'b0;
  localparam bit ACT_DRAIN = 1'b1;

  // An index outside the register map; the core must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'hF;

  typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_e;

  // One line of the directed table. rgb words are {blue, green, red}, as on tdata.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  cfg;
    bit                     action;
    logic [23:0]            rgb;
    bit                     typed;
    bit                     want_last;
    logic [23:0]            want_rgb;
  } probe_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic [0:0]             s_axis_tuser = '0;   // action[0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  box_blur_3x3_stream_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Blur predictor: own copy of the registers, line buffers, window and counters
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] cfg_width_reg  = CFG_DATA_W'(FRAME_WIDTH_RESET);
  logic [CFG_DATA_W-1:0] cfg_height_reg = CFG_DATA_W'(FRAME_HEIGHT_RESET);

  bb_pix_t     upper_mem  [LINE_LEN];
  bb_pix_t     middle_mem [LINE_LEN];
  bb_pix_t     win [9];                 // column-major, three rows per column
  int unsigned in_col  = 0;
  int unsigned in_row  = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;

  bb_res_t     blurred_q [$];           // blurred pixels still owed by the core
  bit          frame_closed = 1'b0;     // set when the predictor emits a frame end

  // Directed rows may pin the expected beat to a hand-computed value.
  bit          literal_armed = 1'b0;
  bb_res_t     literal_res = '0;

  int unsigned fed_beats = 0;
  int unsigned ignored_ticks = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned frames_cut = 0;
  int unsigned reg_writes = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_count = 0;

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;

  function automatic int unsigned width_used();
    if (cfg_width_reg == 0) return 1;
    if (cfg_width_reg > LINE_LEN) return LINE_LEN;
    return cfg_width_reg;
  endfunction

  function automatic int unsigned height_used();
    return (cfg_height_reg == 0) ? 1 : cfg_height_reg;
  endfunction

  function automatic logic [7:0] round_mean(int unsigned sum, int unsigned n);
    int unsigned v;
    if (n == 0) return 8'd0;
    // half up, exact: (2*sum + n) / (2*n)
    v = (2 * sum + n) / (2 * n);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Mean over the in-frame part of the 3x3 patch centered on window column ctr.
  function automatic bb_pix_t window_mean(int ctr, int w, int h);
    int unsigned s_r, s_g, s_b, n;
    int          dc, dr, wc, col, row;
    bb_pix_t     px, res;
    s_r = 0;
    s_g = 0;
    s_b = 0;
    n   = 0;
    for (dc = -1; dc <= 1; dc++) begin
      wc  = ctr + dc;
      col = int'(out_col) + dc;
      if (wc >= 0 && wc <= 2 && col >= 0 && col < w) begin
        for (dr = -1; dr <= 1; dr++) begin
          row = int'(out_row) + dr;
          if (row >= 0 && row < h) begin
            px = win[wc * 3 + dr + 1];
            s_r += px.red;
            s_g += px.green;
            s_b += px.blue;
            n++;
          end
        end
      end
    end
    res.red   = round_mean(s_r, n);
    res.green = round_mean(s_g, n);
    res.blue  = round_mean(s_b, n);
    return res;
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void owe_result(bb_pix_t pix, bit last);
    bb_res_t r;
    r.frame_end = last;
    r.pix       = pix;
    blurred_q.push_back(literal_armed ? literal_res : r);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) begin
      cfg_width_reg = val;
      restart_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      cfg_height_reg = val;
      restart_frame();
    end
  endfunction

  // Advance the predictor by one accepted input beat.
  function automatic void predict_blur_beat(bit action, bb_pix_t px_in);
    int unsigned w, h, c, i;
    bb_pix_t     top, mid, px, mean;
    bit          emit;
    w    = width_used();
    h    = height_used();
    px   = '0;
    mean = '0;
    emit = 1'b0;
    if (in_row < h) begin
      // Drain ticks inside the frame change nothing.
      if (action == ACT_DRAIN) begin
        ignored_ticks++;
        return;
      end
      px = px_in;
    end
    // Past the last row every beat is a drain tick; pixel data is dropped.
    fed_beats++;
    c   = in_col % LINE_LEN;
    top = upper_mem[c];
    mid = middle_mem[c];
    upper_mem[c]  = mid;
    middle_mem[c] = px;
    // Column zero finishes the previous row's last pixel before the shift.
    if (in_col == 0 && in_row >= 2) begin
      mean = window_mean(2, w, h);
      emit = 1'b1;
    end
    for (i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = top;
    win[7] = mid;
    win[8] = px;
    if (in_col != 0 && in_row >= 1) begin
      mean = window_mean(1, w, h);
      emit = 1'b1;
    end
    if (emit) begin
      if (out_row + 1 >= h && out_col + 1 >= w) begin
        owe_result(mean, 1'b1);
        frames_done++;
        frame_closed = 1'b1;
        restart_frame();
        return;
      end
      owe_result(mean, 1'b0);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic check_result();
    bb_res_t want;
    bb_pix_t got;
    results_seen++;
    got = bb_pix_t'(m_axis_tdata);
    if (blurred_q.size() == 0) begin
      report_mismatch("unexpected output beat", {m_axis_tlast, m_axis_tdata}, 0);
      return;
    end
    want = blurred_q.pop_front();
    if (got.red != want.pix.red) report_mismatch("red", got.red, want.pix.red);
    if (got.green != want.pix.green) report_mismatch("green", got.green, want.pix.green);
    if (got.blue != want.pix.blue) report_mismatch("blue", got.blue, want.pix.blue);
    if (m_axis_tlast != want.frame_end) report_mismatch("tlast", m_axis_tlast, want.frame_end);
  endtask

  // All three channels are sampled in one place, at the rising edge, so the
  // predictor and the checker see the same pre-edge values.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_register(cfg_index_i, cfg_data_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_blur_beat(s_axis_tuser[0], bb_pix_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
    end
  end

  // Receiver: stall at random, rate set per phase.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, blurred_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers (all called and returning at a falling edge)
  // ---------------------------------------------------------------------------

  // Leave tvalid high on return so back-to-back beats flow without a bubble.
  task automatic send_beat(bit action, logic [23:0] rgb);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = rgb;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold the input until every owed result has left the core.
  task automatic wait_results_out();
    s_axis_tvalid = 1'b0;
    while (blurred_q.size() != 0) @(negedge clk_i);
  endtask

  // Registers change only with the core idle: nothing owed and the pipe flushed,
  // since beats that yield no result may still be in flight.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_results_out();
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    reg_writes++;
  endtask

  // Channels hit 0 or 255 one time in eight to push the sums to their limits.
  function automatic logic [23:0] random_pixel();
    logic [23:0] rgb;
    int          ch;
    rgb = 24'($urandom());
    for (ch = 0; ch < 3; ch++) begin
      if ($urandom_range(7) == 0) rgb[ch * 8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return rgb;
  endfunction

  // One frame of random content. A cut frame stops early and is abandoned; the
  // next register write restarts the core once the results already owed are out.
  task automatic run_frame(int unsigned wv, int unsigned hv, bit cut, bit hold, bit rewrite);
    int unsigned ew, eh, npix, stop_at, k;
    if (rewrite) begin
      write_register(REG_FRAME_WIDTH, CFG_DATA_W'(wv));
      write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(hv));
    end
    ew   = (wv == 0) ? 1 : (wv > LINE_LEN) ? LINE_LEN : wv;
    eh   = (hv == 0) ? 1 : hv;
    npix = ew * eh;
    stop_at = cut ? $urandom_range((npix - 1 < 64) ? npix - 1 : 64) : npix;
    frame_closed = 1'b0;
    for (k = 0; k < stop_at; k++) begin
      // Stray drain ticks mid-frame must be ignored.
      if ($urandom_range(99) < 4) send_beat(ACT_DRAIN, 24'($urandom()));
      if (hold && k == stop_at / 2) wait_results_out();
      send_beat(ACT_PIXEL, random_pixel());
    end
    if (cut) begin
      frames_cut++;
      return;
    end
    // Flush: mostly drain ticks, some pixels whose data must be dropped.
    while (!frame_closed) begin
      if ($urandom_range(99) < 80) send_beat(ACT_DRAIN, 24'($urandom()));
      else send_beat(ACT_PIXEL, random_pixel());
    end
  endtask

  task automatic run_random_phase(int unsigned tx_pct, int unsigned rx_pct);
    int unsigned goal, wv, hv, r;
    bit          first;
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    goal  = fed_beats + PHASE_BEATS;
    first = 1'b1;
    while (fed_beats < goal) begin
      r  = $urandom_range(99);
      wv = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 40)
                                                     : $urandom_range(0, 2);
      r  = $urandom_range(99);
      hv = (r < 75) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 16)
                                                     : $urandom_range(0, 1);
      run_frame(wv, hv, !first && $urandom_range(9) == 0,
                first || $urandom_range(7) == 0, 1'b1);
      first = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: tiny frames whose output is obvious, plus a 3x3 frame that
  // has a corner, edge and inner pixel for the predictor to work out.
  // ---------------------------------------------------------------------------
  probe_row_t probe_tab [33] = '{
    // after reset (640x480) a drain tick at frame start is ignored
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h123456, 1'b0, 1'b0, 24'h000000},
    // 1x1 frame: the lone pixel averages only itself
    '{ROW_CFG,  REG_FRAME_WIDTH,  12'd1,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 12'd1,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b1, 1'b1, 24'hFFFFFF},
    // 2x1 frame: both outputs are the rounded pair mean, half rounds up
    '{ROW_CFG,  REG_FRAME_WIDTH,  12'd2,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'hFF0000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'hFE01FF, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    // a pixel after the frame acts as a drain tick, its data dropped
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h3CA55A, 1'b1, 1'b0, 24'hFF0180},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b1, 1'b1, 24'hFF0180},
    // 3x3 frame
    '{ROW_CFG,  REG_FRAME_WIDTH,  12'd3,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 12'd3,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h00FF10, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h11E020, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h22C030, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h33A0F0, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h448005, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h5560FF, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h664000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h7720C8, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h880001, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'h000000, 1'b0, 1'b0, 24'h000000},
    // zero width and zero height both behave as one
    '{ROW_CFG,  REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 12'd0,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_PIXEL, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{ROW_BEAT, REG_FRAME_WIDTH,  12'd0,  ACT_DRAIN, 24'hFFFFFF, 1'b1, 1'b1, 24'h000000}
  };

  initial begin
    int unsigned k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_gap_pct   = 14;
    rx_stall_pct = 65;
    for (k = 0; k < $size(probe_tab); k++) begin
      if (probe_tab[k].kind == ROW_CFG) begin
        write_register(probe_tab[k].idx, probe_tab[k].cfg);
      end else begin
        literal_armed = probe_tab[k].typed;
        literal_res   = {probe_tab[k].want_last, probe_tab[k].want_rgb};
        send_beat(probe_tab[k].action, probe_tab[k].rgb);
        literal_armed = 1'b0;
      end
    end

    // Random frames under three flow patterns.
    run_random_phase(14, 65);
    run_random_phase(65, 14);
    run_random_phase(0, 0);

    // An unmapped index must not disturb the 5x4 setting of the frame before it.
    run_frame(5, 4, 1'b0, 1'b0, 1'b1);
    write_register(REG_NONE, 12'hABC);
    run_frame(5, 4, 1'b0, 1'b0, 1'b0);

    // Size extremes: an over-wide row, a tall single column and a full-width
    // tall frame, each cut short after at most 64 pixels.
    run_frame(4095, 1, 1'b1, 1'b0, 1'b1);
    run_frame(1, 4095, 1'b1, 1'b0, 1'b1);
    run_frame(LINE_LEN, 4095, 1'b1, 1'b0, 1'b1);
    write_register(REG_FRAME_WIDTH, 12'd3);

    // Flush and give stray beats time to show.
    wait_results_out();
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (blurred_q.size() != 0) report_mismatch("results never delivered", blurred_q.size(), 0);

    $display("covered %0d stream beats plus %0d ignored drain ticks, %0d output beats checked",
             fed_beats, ignored_ticks, results_seen);
    $display("%0d frames completed, %0d abandoned, %0d register writes, widths up to 4095",
             frames_done, frames_cut, reg_writes);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
